// ===== src/lbs_pkg.sv =====
package lbs_pkg;

   // Command codes carried in the cmd field of a request word.
   localparam logic [2:0] CMD_TICK      = 3'd0;
   localparam logic [2:0] CMD_FLASH_CNT = 3'd1;
   localparam logic [2:0] CMD_FLASH_FOR = 3'd2;
   localparam logic [2:0] CMD_STEADY_ON = 3'd3;
   localparam logic [2:0] CMD_STEADY_OFF = 3'd4;

   // Field widths of the request, response and configuration words.
   localparam int unsigned CMD_W      = 3;
   localparam int unsigned DUR_W      = 16;
   localparam int unsigned COUNT_W    = 8;
   localparam int unsigned STEP_W     = 10;
   localparam int unsigned OUT_W      = 2;
   localparam logic [STEP_W-1:0] STEP_RESET = 10'd10;

   // Per-channel operating mode.
   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_COUNTED = 3'd1,
      MODE_FOREVER = 3'd2,
      MODE_ON      = 3'd3,
      MODE_OFF     = 3'd4
   } lbs_mode_type;

   // Decoded request, broadcast to every channel.
   typedef struct packed {
      logic               tick;
      logic               load_flash;
      logic               counted;
      logic               steady;
      logic               steady_on;
      logic [DUR_W-1:0]   on_time;
      logic [DUR_W-1:0]   off_time;
      logic [COUNT_W-1:0] flash_count;
      logic [STEP_W-1:0]  tick_step;
   } lbs_ctl_type;

   // Channel status after the current word is applied.
   typedef struct packed {
      logic level;
      logic active;
   } lbs_stat_type;

endpackage

// ===== src/lbs_req_if.sv =====
interface lbs_req_if import lbs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic                led_index;
   logic [DUR_W-1:0]    on_time;
   logic [DUR_W-1:0]    off_time;
   logic [COUNT_W-1:0]  flash_count;

   modport source (output valid, cmd, led_index, on_time, off_time, flash_count,
                   input ready);
   modport sink   (input valid, cmd, led_index, on_time, off_time, flash_count,
                   output ready);
endinterface

// ===== src/lbs_rsp_if.sv =====
interface lbs_rsp_if import lbs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] led_levels;
   logic [OUT_W-1:0] active_mask;

   modport source (output valid, led_levels, active_mask, input ready);
   modport sink   (input valid, led_levels, active_mask, output ready);
endinterface

// ===== src/lbs_csr_if.sv =====
interface lbs_csr_if import lbs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STEP_W-1:0] tick_step;

   modport source (output valid, tick_step, input ready);
   modport sink   (input valid, tick_step, output ready);
endinterface

// ===== src/lbs_channel.sv =====
module lbs_channel import lbs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         sel,
   input  lbs_ctl_type  ctl,
   output lbs_stat_type stat
);

   lbs_mode_type       mode_ff, mode_in;
   logic [DUR_W-1:0]   cnt_ff, cnt_in;
   logic               lit_ff, lit_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic [DUR_W-1:0]   lit_dur_ff, lit_dur_in;
   logic [DUR_W-1:0]   dark_dur_ff, dark_dur_in;
   logic               drive_ff, drive_in;

   logic [DUR_W:0]     diff;
   logic               expired;
   logic [COUNT_W-1:0] left_dec;

   // Counter minus step; the phase ends when the result is zero or negative.
   assign diff     = {1'b0, cnt_ff} - {{(DUR_W + 1 - STEP_W){1'b0}}, ctl.tick_step};
   assign expired  = diff[DUR_W] || (diff[DUR_W-1:0] == '0);
   assign left_dec = left_ff - COUNT_W'(1);

   // Next state for a tick or an addressed command.
   always_comb begin
      mode_in     = mode_ff;
      cnt_in      = cnt_ff;
      lit_in      = lit_ff;
      left_in     = left_ff;
      lit_dur_in  = lit_dur_ff;
      dark_dur_in = dark_dur_ff;
      drive_in    = drive_ff;
      if (ctl.tick) begin
         case (mode_ff)
            MODE_ON:  drive_in = 1'b1;
            MODE_OFF: drive_in = 1'b0;
            MODE_COUNTED, MODE_FOREVER: begin
               if (!expired) begin
                  cnt_in = diff[DUR_W-1:0];
               end else if (!lit_ff) begin
                  drive_in = 1'b1;
                  cnt_in   = lit_dur_ff;
                  lit_in   = 1'b1;
               end else begin
                  drive_in = 1'b0;
                  cnt_in   = dark_dur_ff;
                  lit_in   = 1'b0;
                  if (mode_ff == MODE_COUNTED) begin
                     left_in = left_dec;
                     if (left_dec == '0) begin
                        mode_in = MODE_IDLE;
                     end
                  end
               end
            end
            default: ;
         endcase
      end else if (sel) begin
         if (ctl.load_flash) begin
            lit_in      = 1'b0;
            lit_dur_in  = ctl.on_time;
            dark_dur_in = ctl.off_time;
            cnt_in      = '0;
            if (ctl.counted) begin
               left_in = ctl.flash_count;
               mode_in = MODE_COUNTED;
            end else begin
               mode_in = MODE_FOREVER;
            end
         end else if (ctl.steady) begin
            mode_in = ctl.steady_on ? MODE_ON : MODE_OFF;
         end
      end
   end

   // Channel state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         cnt_ff      <= '0;
         lit_ff      <= 1'b0;
         left_ff     <= '0;
         lit_dur_ff  <= '0;
         dark_dur_ff <= '0;
         drive_ff    <= 1'b0;
      end else if (en) begin
         mode_ff     <= mode_in;
         cnt_ff      <= cnt_in;
         lit_ff      <= lit_in;
         left_ff     <= left_in;
         lit_dur_ff  <= lit_dur_in;
         dark_dur_ff <= dark_dur_in;
         drive_ff    <= drive_in;
      end
   end

   // Status as it stands once this word is applied.
   assign stat.level  = drive_in;
   assign stat.active = (mode_in != MODE_IDLE);

endmodule

// ===== src/led_blink_sequencer.sv =====
// Channel  Port      Direction  Word contents
// request  req_chan  in         cmd, led_index, on_time, off_time, flash_count
// response rsp_chan  out        led_levels, active_mask
// config   csr_chan  in         tick_step (always ready)
//
// Each request word produces exactly one response word, held first in the input
// register and then in the response register. One word per cycle is sustained
// while the response side is ready; the only storage per word is that input
// register and the response register. Reset is synchronous and clears all
// channels to idle and dark, and tick_step to 10. A stalled response holds the
// pipeline, and the request side stalls only when both registers are full.
module led_blink_sequencer import lbs_pkg::*; #(
   parameter int unsigned NUM_CHANNELS = 2
) (
   input  logic clock,
   input  logic reset,
   lbs_req_if.sink   req_chan,
   lbs_rsp_if.source rsp_chan,
   lbs_csr_if.sink   csr_chan
);

   logic [STEP_W-1:0]  step_ff;
   logic               s1_valid_ff;
   logic [CMD_W-1:0]   s1_cmd_ff;
   logic               s1_idx_ff;
   logic [DUR_W-1:0]   s1_on_ff;
   logic [DUR_W-1:0]   s1_off_ff;
   logic [COUNT_W-1:0] s1_count_ff;
   logic               out_valid_ff;
   logic [OUT_W-1:0]   out_levels_ff, out_levels_in;
   logic [OUT_W-1:0]   out_active_ff, out_active_in;

   logic               advance;
   logic               cmd_ok;
   lbs_ctl_type        ctl;
   lbs_stat_type       stat [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] sel;

   // Configuration register.
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (csr_chan.valid) begin
         step_ff <= csr_chan.tick_step;
      end
   end

   // Pipeline flow control.
   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_cmd_ff   <= req_chan.cmd;
         s1_idx_ff   <= req_chan.led_index;
         s1_on_ff    <= req_chan.on_time;
         s1_off_ff   <= req_chan.off_time;
         s1_count_ff <= req_chan.flash_count;
      end
   end

   // Command decode; unknown codes leave every channel alone.
   always_comb begin
      ctl             = '0;
      ctl.on_time     = s1_on_ff;
      ctl.off_time    = s1_off_ff;
      ctl.flash_count = s1_count_ff;
      ctl.tick_step   = step_ff;
      cmd_ok          = 1'b1;
      unique case (s1_cmd_ff)
         CMD_TICK:       ctl.tick = 1'b1;
         CMD_FLASH_CNT:  begin
            ctl.load_flash = 1'b1;
            ctl.counted    = 1'b1;
         end
         CMD_FLASH_FOR:  ctl.load_flash = 1'b1;
         CMD_STEADY_ON:  begin
            ctl.steady    = 1'b1;
            ctl.steady_on = 1'b1;
         end
         CMD_STEADY_OFF: ctl.steady = 1'b1;
         default:        cmd_ok = 1'b0;
      endcase
   end

   // Channel array.
   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
      assign sel[c] = cmd_ok && (32'(s1_idx_ff) == c);
      lbs_channel u_chan (
         .clock (clock),
         .reset (reset),
         .en    (advance),
         .sel   (sel[c]),
         .ctl   (ctl),
         .stat  (stat[c])
      );
   end

   // Only the first channels appear in the response word.
   for (genvar b = 0; b < OUT_W; b++) begin : g_out
      if (b < NUM_CHANNELS) begin : g_live
         assign out_levels_in[b] = stat[b].level;
         assign out_active_in[b] = stat[b].active;
      end else begin : g_none
         assign out_levels_in[b] = 1'b0;
         assign out_active_in[b] = 1'b0;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_levels_ff <= out_levels_in;
         out_active_ff <= out_active_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.led_levels  = out_levels_ff;
   assign rsp_chan.active_mask = out_active_ff;

endmodule
